// ===== rtl/core/rmvg_pkg.sv =====
`default_nettype none

package rmvg_pkg;

    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int MAX_COUNT_DEF    = 1024;

    localparam int RADIUS_W = 16;
    localparam int PHASE_W  = 32;
    localparam int COUNT_W  = 11;
    localparam int COORD_W  = 17;
    localparam int SINE_W   = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    localparam logic [RADIUS_W-1:0] RESET_INNER_RADIUS = 16'd256;
    localparam logic [RADIUS_W-1:0] RESET_RING_WIDTH   = 16'd256;
    localparam logic [PHASE_W-1:0]  RESET_ANGLE_STEP   = 32'h1000_0000;
    localparam logic [COUNT_W-1:0]  RESET_SLICES       = 11'd16;
    localparam logic [COUNT_W-1:0]  RESET_RINGS        = 11'd4;

    // six vertices per quad, numbered 0..5
    localparam logic [2:0] LAST_VERTEX = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INNER_RADIUS = 3'd0,
        REG_RING_WIDTH   = 3'd1,
        REG_ANGLE_STEP   = 3'd2,
        REG_SLICES       = 3'd3,
        REG_RINGS        = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] inner_radius;
        logic [RADIUS_W-1:0] ring_width;
        logic [PHASE_W-1:0]  angle_step;
        logic [COUNT_W-1:0]  slices;
        logic [COUNT_W-1:0]  rings;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0]  a1;
        logic [PHASE_W-1:0]  a2;
        logic [RADIUS_W-1:0] ri;
        logic [RADIUS_W-1:0] ro;
        logic                last_mesh;
    } quad_t;

endpackage

`default_nettype wire

// ===== rtl/core/rmvg_cfg_regs.sv =====
`default_nettype none

module rmvg_cfg_regs
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rmvg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rmvg_pkg::CFG_W-1:0]      cfg_data,
    output rmvg_pkg::cfg_t                       cfg
);

    rmvg_pkg::cfg_t cfg_reg;
    rmvg_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (rmvg_pkg::cfg_index_t'(cfg_index))
                rmvg_pkg::REG_INNER_RADIUS:
                    cfg_next.inner_radius = cfg_data[rmvg_pkg::RADIUS_W-1:0];
                rmvg_pkg::REG_RING_WIDTH:
                    cfg_next.ring_width = cfg_data[rmvg_pkg::RADIUS_W-1:0];
                rmvg_pkg::REG_ANGLE_STEP:
                    cfg_next.angle_step = cfg_data[rmvg_pkg::PHASE_W-1:0];
                rmvg_pkg::REG_SLICES:
                    cfg_next.slices = cfg_data[rmvg_pkg::COUNT_W-1:0];
                rmvg_pkg::REG_RINGS:
                    cfg_next.rings = cfg_data[rmvg_pkg::COUNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inner_radius <= rmvg_pkg::RESET_INNER_RADIUS;
            cfg_reg.ring_width   <= rmvg_pkg::RESET_RING_WIDTH;
            cfg_reg.angle_step   <= rmvg_pkg::RESET_ANGLE_STEP;
            cfg_reg.slices       <= rmvg_pkg::RESET_SLICES;
            cfg_reg.rings        <= rmvg_pkg::RESET_RINGS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rmvg_quad_gen.sv =====
`default_nettype none

module rmvg_quad_gen
#(
    parameter int MAX_COUNT = rmvg_pkg::MAX_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire rmvg_pkg::cfg_t cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        restart,
    output rmvg_pkg::quad_t  quad,
    output logic             quad_valid,
    input  wire logic        quad_take
);

    localparam int IW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int EW = (CW > rmvg_pkg::COUNT_W) ? CW : rmvg_pkg::COUNT_W;
    localparam int RW = rmvg_pkg::RADIUS_W;
    localparam int PW = rmvg_pkg::PHASE_W;

    logic [IW-1:0] ring_reg, ring_next;
    logic [IW-1:0] slice_reg, slice_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic [RW-1:0] ri_reg, ri_next;
    logic [RW-1:0] ro_reg, ro_next;
    rmvg_pkg::quad_t quad_reg;
    logic            quad_valid_reg;

    logic [EW-1:0] ns, nr;
    logic [IW-1:0] cur_ring, cur_slice;
    logic [PW-1:0] cur_phase, a2;
    logic [RW-1:0] cur_ri, cur_ro, start_ro, grow_ro;
    logic [RW:0]   start_sum, grow_sum;
    logic [EW-1:0] slice_inc, ring_inc;
    logic          slice_wrap, ring_wrap;
    logic          accept;

    // zero acts as one, above the limit acts as the limit
    always_comb
    begin
        ns = EW'(cfg.slices);
        priority if (ns == '0)
            ns = EW'(1);
        else if (ns > EW'(MAX_COUNT))
            ns = EW'(MAX_COUNT);

        nr = EW'(cfg.rings);
        priority if (nr == '0)
            nr = EW'(1);
        else if (nr > EW'(MAX_COUNT))
            nr = EW'(MAX_COUNT);
    end

    assign start_sum = {1'b0, cfg.inner_radius} + {1'b0, cfg.ring_width};
    assign start_ro  = start_sum[RW] ? {RW{1'b1}} : start_sum[RW-1:0];

    always_comb
    begin
        if (restart)
        begin
            cur_ring  = '0;
            cur_slice = '0;
            cur_phase = '0;
            cur_ri    = cfg.inner_radius;
            cur_ro    = start_ro;
        end
        else
        begin
            cur_ring  = ring_reg;
            cur_slice = slice_reg;
            cur_phase = phase_reg;
            cur_ri    = ri_reg;
            cur_ro    = ro_reg;
        end
    end

    assign a2         = cur_phase + cfg.angle_step;
    assign slice_inc  = EW'(cur_slice) + EW'(1);
    assign ring_inc   = EW'(cur_ring) + EW'(1);
    assign slice_wrap = (slice_inc >= ns);
    assign ring_wrap  = (ring_inc >= nr);
    assign grow_sum   = {1'b0, cur_ro} + {1'b0, cfg.ring_width};
    assign grow_ro    = grow_sum[RW] ? {RW{1'b1}} : grow_sum[RW-1:0];

    always_comb
    begin
        ring_next  = cur_ring;
        slice_next = slice_inc[IW-1:0];
        phase_next = a2;
        ri_next    = cur_ri;
        ro_next    = cur_ro;
        if (slice_wrap)
        begin
            if (ring_wrap)
            begin
                // mesh done: back to the first quad
                ring_next  = '0;
                slice_next = '0;
                phase_next = '0;
                ri_next    = cfg.inner_radius;
                ro_next    = start_ro;
            end
            else
            begin
                ring_next  = ring_inc[IW-1:0];
                slice_next = '0;
                ri_next    = cur_ro;
                ro_next    = grow_ro;
            end
        end
    end

    assign in_ready = !quad_valid_reg || quad_take;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg       <= '0;
            slice_reg      <= '0;
            phase_reg      <= '0;
            ri_reg         <= rmvg_pkg::RESET_INNER_RADIUS;
            ro_reg         <= rmvg_pkg::RESET_INNER_RADIUS + rmvg_pkg::RESET_RING_WIDTH;
            quad_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ring_reg       <= ring_next;
                slice_reg      <= slice_next;
                phase_reg      <= phase_next;
                ri_reg         <= ri_next;
                ro_reg         <= ro_next;
                quad_valid_reg <= 1'b1;
            end
            else if (quad_take)
            begin
                quad_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            quad_reg.a1        <= cur_phase;
            quad_reg.a2        <= a2;
            quad_reg.ri        <= cur_ri;
            quad_reg.ro        <= cur_ro;
            quad_reg.last_mesh <= slice_wrap && ring_wrap;
        end
    end

    assign quad       = quad_reg;
    assign quad_valid = quad_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rmvg_sine_rom.sv =====
`default_nettype none

module rmvg_sine_rom
#(
    parameter int SINE_ENTRIES = rmvg_pkg::SINE_ENTRIES_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [$clog2(SINE_ENTRIES)-1:0]     sin_addr,
    input  wire logic [$clog2(SINE_ENTRIES)-1:0]     cos_addr,
    output logic signed [rmvg_pkg::SINE_W-1:0]       sin_q,
    output logic signed [rmvg_pkg::SINE_W-1:0]       cos_q
);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // sin(2*pi*i/N) in Q2.14, Taylor series in Q30 on the folded quarter-wave angle
    function automatic logic signed [rmvg_pkg::SINE_W-1:0] sine_entry(input int unsigned i);
        longint unsigned q4;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned num;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          s;
        q4   = 64'(i) * 64'd4;
        quad = q4 / SINE_ENTRIES;
        rem  = q4 % SINE_ENTRIES;
        num  = quad[0] ? (64'(SINE_ENTRIES) - rem) : rem;
        x    = (HALF_PI_Q30 * num) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0)
            sum = 0;
        s = (sum + 64'sd32768) >>> 16;
        if (s > 64'sd16384)
            s = 64'sd16384;
        if (quad >= 64'd2)
            s = -s;
        return rmvg_pkg::SINE_W'(s);
    endfunction

    logic signed [rmvg_pkg::SINE_W-1:0] rom [SINE_ENTRIES];
    logic signed [rmvg_pkg::SINE_W-1:0] sin_reg;
    logic signed [rmvg_pkg::SINE_W-1:0] cos_reg;

    for (genvar g = 0; g < SINE_ENTRIES; g++)
    begin : g_rom
        assign rom[g] = sine_entry(g);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= rom[sin_addr];
            cos_reg <= rom[cos_addr];
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rmvg_vertex_pipe.sv =====
`default_nettype none

module rmvg_vertex_pipe
#(
    parameter int SINE_ENTRIES = rmvg_pkg::SINE_ENTRIES_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rmvg_pkg::quad_t                    quad,
    input  wire logic                               quad_valid,
    output logic                                    quad_take,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [rmvg_pkg::COORD_W-1:0]     x_coord,
    output logic signed [rmvg_pkg::COORD_W-1:0]     z_coord,
    output logic                                    last_of_quad,
    output logic                                    last_of_mesh
);

    localparam int AW = $clog2(SINE_ENTRIES);
    localparam int RW = rmvg_pkg::RADIUS_W;
    localparam int SW = rmvg_pkg::SINE_W;
    localparam int CW = rmvg_pkg::COORD_W;
    localparam int PRW = RW + 1 + SW;
    localparam logic [AW-1:0] QUARTER = AW'(SINE_ENTRIES / 4);

    logic          adv;
    logic [2:0]    vtx_reg, vtx_next;
    logic [RW-1:0] sel_r;
    logic [rmvg_pkg::PHASE_W-1:0] sel_ph;
    logic          sel_lq;
    logic [AW-1:0] sin_addr, cos_addr;

    logic          s1_valid_reg;
    logic [RW-1:0] s1_r_reg;
    logic          s1_lq_reg, s1_lm_reg;
    logic signed [SW-1:0] sin_q, cos_q;

    logic          s2_valid_reg;
    logic signed [PRW-1:0] s2_x_reg, s2_z_reg;
    logic          s2_lq_reg, s2_lm_reg;

    logic signed [PRW:0] x_round, z_round;
    logic          out_valid_reg;
    logic signed [CW-1:0] x_reg, z_reg;
    logic          lq_reg, lm_reg;

    // whole pipeline moves together unless the output is held
    assign adv       = !out_valid_reg || out_ready;
    assign quad_take = adv && quad_valid && (vtx_reg == rmvg_pkg::LAST_VERTEX);

    // vertex order: inner@a1, outer@a1, inner@a2, inner@a2, outer@a1, outer@a2
    always_comb
    begin
        sel_lq = 1'b0;
        unique case (vtx_reg)
            3'd0:
            begin
                sel_r  = quad.ri;
                sel_ph = quad.a1;
            end
            3'd1, 3'd4:
            begin
                sel_r  = quad.ro;
                sel_ph = quad.a1;
            end
            3'd2, 3'd3:
            begin
                sel_r  = quad.ri;
                sel_ph = quad.a2;
            end
            3'd5:
            begin
                sel_r  = quad.ro;
                sel_ph = quad.a2;
                sel_lq = 1'b1;
            end
            default:
            begin
                sel_r  = quad.ro;
                sel_ph = quad.a2;
            end
        endcase
    end

    assign sin_addr = sel_ph[rmvg_pkg::PHASE_W-1 -: AW];
    assign cos_addr = sin_addr + QUARTER;

    always_comb
    begin
        vtx_next = vtx_reg;
        if (adv && quad_valid)
        begin
            vtx_next = (vtx_reg == rmvg_pkg::LAST_VERTEX) ? 3'd0 : vtx_reg + 3'd1;
        end
    end

    rmvg_sine_rom
    #(
        .SINE_ENTRIES (SINE_ENTRIES)
    )
    u_rom
    (
        .clk      (clk),
        .en       (adv),
        .sin_addr (sin_addr),
        .cos_addr (cos_addr),
        .sin_q    (sin_q),
        .cos_q    (cos_q)
    );

    // round half away from zero on the 14 fraction bits of the table
    assign x_round = (PRW+1)'(s2_x_reg) + (s2_x_reg[PRW-1] ? (PRW+1)'(8191) : (PRW+1)'(8192));
    assign z_round = (PRW+1)'(s2_z_reg) + (s2_z_reg[PRW-1] ? (PRW+1)'(8191) : (PRW+1)'(8192));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_reg       <= 3'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vtx_reg <= vtx_next;
            if (adv)
            begin
                s1_valid_reg  <= quad_valid;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_r_reg  <= sel_r;
            s1_lq_reg <= sel_lq;
            s1_lm_reg <= quad.last_mesh;

            s2_x_reg  <= $signed({1'b0, s1_r_reg}) * sin_q;
            s2_z_reg  <= $signed({1'b0, s1_r_reg}) * cos_q;
            s2_lq_reg <= s1_lq_reg;
            s2_lm_reg <= s1_lm_reg;

            x_reg  <= x_round[14 +: CW];
            z_reg  <= z_round[14 +: CW];
            lq_reg <= s2_lq_reg;
            lm_reg <= s2_lm_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_coord      = x_reg;
    assign z_coord      = z_reg;
    assign last_of_quad = lq_reg;
    assign last_of_mesh = lm_reg;

`ifndef NO_ASSERTIONS
    a_vtx_range: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_reg <= rmvg_pkg::LAST_VERTEX)
        else $error("vertex counter out of range");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(vtx_reg) && $stable(s1_valid_reg))
        else $error("pipeline moved while output held");

    a_issue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        adv && quad_valid |=> s1_valid_reg)
        else $error("issued vertex lost in first stage");

    a_mesh_flag_quad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ready && !lq_reg |=> !out_valid_reg || (lm_reg == $past(lm_reg)))
        else $error("mesh flag changed inside a quad");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ring_mesh_vertex_generator.sv =====
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata[0] restart
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata x, z; tlast quad end; tuser mesh end
// cfg       in   cfg_we (no wait)                cfg_index, cfg_data
//
// Each item yields six vertices, one per cycle unless the output is held; a vertex
// counter in the vertex pipeline steps through them. Each vertex passes the table
// read, multiply and round registers. The next item is taken while the sixth vertex
// issues. Reset clears control state and loads the register defaults. A held output
// freezes the whole vertex pipeline; the quad register keeps one item.
`default_nettype none

module ring_mesh_vertex_generator
#(
    parameter int SINE_ENTRIES = rmvg_pkg::SINE_ENTRIES_DEF,
    parameter int MAX_COUNT    = rmvg_pkg::MAX_COUNT_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [rmvg_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [0] restart
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [rmvg_pkg::OUT_DATA_W-1:0]         m_axis_tdata,   // [16:0] x_coord, [33:17] z_coord
    output logic                                    m_axis_tlast,   // last_of_quad
    output logic                                    m_axis_tuser,   // last_of_mesh
    input  wire logic                               cfg_we,
    input  wire logic [rmvg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rmvg_pkg::CFG_W-1:0]         cfg_data
);

    rmvg_pkg::cfg_t  cfg;
    rmvg_pkg::quad_t quad;
    logic            quad_valid;
    logic            quad_take;
    logic signed [rmvg_pkg::COORD_W-1:0] x_coord;
    logic signed [rmvg_pkg::COORD_W-1:0] z_coord;

    rmvg_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rmvg_quad_gen
    #(
        .MAX_COUNT (MAX_COUNT)
    )
    u_quad
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .restart    (s_axis_tdata[0]),
        .quad       (quad),
        .quad_valid (quad_valid),
        .quad_take  (quad_take)
    );

    rmvg_vertex_pipe
    #(
        .SINE_ENTRIES (SINE_ENTRIES)
    )
    u_vtx
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .quad         (quad),
        .quad_valid   (quad_valid),
        .quad_take    (quad_take),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .x_coord      (x_coord),
        .z_coord      (z_coord),
        .last_of_quad (m_axis_tlast),
        .last_of_mesh (m_axis_tuser)
    );

    assign m_axis_tdata = {
        (rmvg_pkg::OUT_DATA_W - 2 * rmvg_pkg::COORD_W)'(0),
        z_coord,
        x_coord
    };

endmodule

`default_nettype wire
